// ===== hw/rtl/bpsa_pkg.sv =====
// Package for the binary patch stream applier: field widths, codes, result
// types and the header magic. No dependencies.
package bpsa_pkg;

   localparam int CMD_W  = 2;
   localparam int BYTE_W = 8;
   localparam int WORD_W = 32;
   localparam int KIND_W = 2;
   localparam int CODE_W = 3;
   localparam int DEST_W = 34;
   localparam int IDX_W  = 4;

   // request commands
   localparam logic [CMD_W-1:0] CMD_PATCH  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_END    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SOURCE = 2'd2;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_BYTE  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FETCH = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DONE  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_ERROR = 2'd3;

   // error codes
   localparam logic [CODE_W-1:0] ERR_BAD_HEADER = 3'd0;
   localparam logic [CODE_W-1:0] ERR_EARLY_END  = 3'd1;
   localparam logic [CODE_W-1:0] ERR_BAD_RANGE  = 3'd2;
   localparam logic [CODE_W-1:0] ERR_CHECKSUM   = 3'd3;
   localparam logic [CODE_W-1:0] ERR_BAD_TAG    = 3'd4;
   localparam logic [CODE_W-1:0] ERR_TOO_LONG   = 3'd5;
   localparam logic [CODE_W-1:0] ERR_TOO_SHORT  = 3'd6;

   // section tags
   localparam logic [BYTE_W-1:0] TAG_COPY    = 8'h40;
   localparam logic [BYTE_W-1:0] TAG_LITERAL = 8'h2B;

   // header byte positions
   localparam logic [IDX_W-1:0] IDX_MAGIC_LAST = 4'd7;
   localparam logic [IDX_W-1:0] IDX_SRC_LAST   = 4'd11;
   localparam logic [IDX_W-1:0] IDX_HDR_LAST   = 4'd15;
   // copy / literal section header byte positions
   localparam logic [IDX_W-1:0] IDX_FIELD0_LAST = 4'd3;
   localparam logic [IDX_W-1:0] IDX_FIELD1_LAST = 4'd7;
   localparam logic [IDX_W-1:0] IDX_FIELD2_LAST = 4'd11;

   localparam logic [BYTE_W-1:0] MAGIC [8] = '{
      8'h62, 8'h64, 8'h69, 8'h66, 8'h66, 8'h30, 8'h32, 8'h1A
   };

   typedef enum logic [3:0] {
      PH_HEADER  = 4'd0,
      PH_TAG     = 4'd1,
      PH_COPYHDR = 4'd2,
      PH_LITHDR  = 4'd3,
      PH_SOURCE  = 4'd4,
      PH_LITERAL = 4'd5
   } phase_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [BYTE_W-1:0] out_byte;
      logic [WORD_W-1:0] fetch_offset;
      logic [WORD_W-1:0] fetch_length;
      logic [CODE_W-1:0] error_code;
      logic              last;
   } rsp_type;

   // up to two results from one request word; second valid implies first
   typedef struct packed {
      logic    v0;
      logic    v1;
      rsp_type r0;
      rsp_type r1;
   } push_type;

   function automatic rsp_type bpsa_byte(input logic [BYTE_W-1:0] b);
      rsp_type r;
      r          = '0;
      r.kind     = KIND_BYTE;
      r.out_byte = b;
      return r;
   endfunction

   function automatic rsp_type bpsa_err(input logic [CODE_W-1:0] code,
                                        input logic [BYTE_W-1:0] b);
      rsp_type r;
      r            = '0;
      r.kind       = KIND_ERROR;
      r.out_byte   = b;
      r.error_code = code;
      return r;
   endfunction

   function automatic rsp_type bpsa_fetch(input logic [WORD_W-1:0] ofs,
                                          input logic [WORD_W-1:0] len);
      rsp_type r;
      r              = '0;
      r.kind         = KIND_FETCH;
      r.fetch_offset = ofs;
      r.fetch_length = len;
      return r;
   endfunction

   function automatic rsp_type bpsa_done();
      rsp_type r;
      r      = '0;
      r.kind = KIND_DONE;
      return r;
   endfunction

endpackage

// ===== hw/rtl/bpsa_if.sv =====
// Valid/ready channel interfaces for request and response words.
// Depends on bpsa_pkg.
interface bpsa_req_if;
   import bpsa_pkg::*;
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [BYTE_W-1:0] data;
   modport source (output valid, cmd, data, input ready);
   modport sink   (input valid, cmd, data, output ready);
endinterface

interface bpsa_rsp_if;
   import bpsa_pkg::*;
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [BYTE_W-1:0] out_byte;
   logic [WORD_W-1:0] fetch_offset;
   logic [WORD_W-1:0] fetch_length;
   logic [CODE_W-1:0] error_code;
   logic              last;
   modport source (output valid, kind, out_byte, fetch_offset, fetch_length, error_code,
                   last, input ready);
   modport sink   (input valid, kind, out_byte, fetch_offset, fetch_length, error_code,
                   last, output ready);
endinterface

// ===== hw/rtl/bpsa_core.sv =====
// Patch parser state and per-word update: header check, section parsing,
// checksum and destination length tracking. Depends on bpsa_pkg.
module bpsa_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic [bpsa_pkg::CMD_W-1:0]  cmd,
   input  logic [bpsa_pkg::BYTE_W-1:0] data,
   output bpsa_pkg::push_type        push
);
   import bpsa_pkg::*;

   phase_type          phase_ff, phase_in;
   logic [IDX_W-1:0]   count_ff, count_in;
   logic               magic_bad_ff, magic_bad_in;
   logic [WORD_W-1:0]  assembly_ff, assembly_in;
   logic [WORD_W-1:0]  source_len_ff, source_len_in;
   logic [DEST_W-1:0]  remaining_ff, remaining_in;
   logic [WORD_W-1:0]  copy_offset_ff, copy_offset_in;
   logic [WORD_W-1:0]  copy_length_ff, copy_length_in;
   logic [WORD_W-1:0]  expected_ff, expected_in;
   logic [WORD_W-1:0]  running_ff, running_in;
   logic [WORD_W-1:0]  bytes_left_ff, bytes_left_in;

   logic               go_header;
   logic               e0_v, e1_v;
   rsp_type            e0, e1;
   logic [WORD_W-1:0]  shifted;
   logic [WORD_W-1:0]  check_new;
   logic [WORD_W-1:0]  left_dec;
   logic [DEST_W-1:0]  dest_after;
   logic [DEST_W-1:0]  dest_lit_zero;
   logic [WORD_W:0]    range_end;
   logic               range_bad;

   assign shifted   = {data, assembly_ff[WORD_W-1:BYTE_W]};
   assign check_new = {running_ff[WORD_W-3:0], running_ff[WORD_W-1:WORD_W-2]}
                      ^ {{(WORD_W-BYTE_W){data[BYTE_W-1]}}, data};
   assign left_dec  = bytes_left_ff - WORD_W'(1);
   assign dest_after    = remaining_ff - {{(DEST_W-WORD_W){1'b0}}, copy_length_ff};
   assign dest_lit_zero = remaining_ff;
   assign range_end = {1'b0, copy_offset_ff} + {1'b0, copy_length_ff};
   assign range_bad = (copy_length_ff == '0) || (range_end > {1'b0, source_len_ff});

   always_comb begin
      phase_in       = phase_ff;
      count_in       = count_ff;
      magic_bad_in   = magic_bad_ff;
      assembly_in    = assembly_ff;
      source_len_in  = source_len_ff;
      remaining_in   = remaining_ff;
      copy_offset_in = copy_offset_ff;
      copy_length_in = copy_length_ff;
      expected_in    = expected_ff;
      running_in     = running_ff;
      bytes_left_in  = bytes_left_ff;
      go_header      = 1'b0;
      e0_v           = 1'b0;
      e1_v           = 1'b0;
      e0             = '0;
      e1             = '0;

      if (accept) begin
         priority if (phase_ff == PH_SOURCE) begin
            if (cmd == CMD_SOURCE) begin
               running_in    = check_new;
               bytes_left_in = left_dec;
               e0_v          = 1'b1;
               e0            = bpsa_byte(data);
               if (left_dec == '0) begin
                  if (check_new != expected_ff) begin
                     e1_v      = 1'b1;
                     e1        = bpsa_err(ERR_CHECKSUM, '0);
                     go_header = 1'b1;
                  end else begin
                     remaining_in = dest_after;
                     if (dest_after[DEST_W-1]) begin
                        e1_v      = 1'b1;
                        e1        = bpsa_err(ERR_TOO_LONG, '0);
                        go_header = 1'b1;
                     end else begin
                        phase_in = PH_TAG;
                     end
                  end
               end
            end
         end else if (cmd == CMD_END) begin
            e0_v      = 1'b1;
            go_header = 1'b1;
            if (phase_ff == PH_HEADER) begin
               e0 = bpsa_err(ERR_BAD_HEADER, '0);
            end else if (phase_ff == PH_TAG) begin
               e0 = (remaining_ff != '0) ? bpsa_err(ERR_TOO_SHORT, '0) : bpsa_done();
            end else begin
               e0 = bpsa_err(ERR_EARLY_END, '0);
            end
         end else if (cmd == CMD_PATCH) begin
            unique case (phase_ff)
               PH_HEADER: begin
                  if (count_ff <= IDX_MAGIC_LAST) begin
                     if (data != MAGIC[count_ff[2:0]]) begin
                        magic_bad_in = 1'b1;
                     end
                  end else begin
                     assembly_in = shifted;
                  end
                  if (count_ff == IDX_SRC_LAST) begin
                     source_len_in = shifted;
                  end
                  if (count_ff == IDX_HDR_LAST) begin
                     remaining_in = {{(DEST_W-WORD_W){1'b0}}, shifted};
                     if (magic_bad_ff) begin
                        e0_v      = 1'b1;
                        e0        = bpsa_err(ERR_BAD_HEADER, '0);
                        go_header = 1'b1;
                     end else begin
                        phase_in = PH_TAG;
                        count_in = '0;
                     end
                  end else begin
                     count_in = count_ff + IDX_W'(1);
                  end
               end
               PH_TAG: begin
                  count_in = '0;
                  if (data == TAG_COPY) begin
                     phase_in = PH_COPYHDR;
                  end else if (data == TAG_LITERAL) begin
                     phase_in = PH_LITHDR;
                  end else begin
                     e0_v      = 1'b1;
                     e0        = bpsa_err(ERR_BAD_TAG, data);
                     go_header = 1'b1;
                  end
               end
               PH_COPYHDR: begin
                  assembly_in = shifted;
                  count_in    = count_ff + IDX_W'(1);
                  if (count_ff == IDX_FIELD0_LAST) begin
                     copy_offset_in = shifted;
                  end else if (count_ff == IDX_FIELD1_LAST) begin
                     copy_length_in = shifted;
                  end else if (count_ff == IDX_FIELD2_LAST) begin
                     expected_in = shifted;
                     count_in    = '0;
                     e0_v        = 1'b1;
                     if (range_bad) begin
                        e0        = bpsa_err(ERR_BAD_RANGE, '0);
                        go_header = 1'b1;
                     end else begin
                        e0            = bpsa_fetch(copy_offset_ff, copy_length_ff);
                        running_in    = '0;
                        bytes_left_in = copy_length_ff;
                        phase_in      = PH_SOURCE;
                     end
                  end
               end
               PH_LITHDR: begin
                  assembly_in = shifted;
                  count_in    = count_ff + IDX_W'(1);
                  if (count_ff == IDX_FIELD0_LAST) begin
                     count_in       = '0;
                     copy_length_in = shifted;
                     bytes_left_in  = shifted;
                     if (shifted == '0) begin
                        // empty literal run closes the section at once
                        remaining_in = dest_lit_zero;
                        if (dest_lit_zero[DEST_W-1]) begin
                           e0_v      = 1'b1;
                           e0        = bpsa_err(ERR_TOO_LONG, '0);
                           go_header = 1'b1;
                        end else begin
                           phase_in = PH_TAG;
                        end
                     end else begin
                        phase_in = PH_LITERAL;
                     end
                  end
               end
               PH_LITERAL: begin
                  e0_v          = 1'b1;
                  e0            = bpsa_byte(data);
                  bytes_left_in = left_dec;
                  if (left_dec == '0) begin
                     remaining_in = dest_after;
                     if (dest_after[DEST_W-1]) begin
                        e1_v      = 1'b1;
                        e1        = bpsa_err(ERR_TOO_LONG, '0);
                        go_header = 1'b1;
                     end else begin
                        phase_in = PH_TAG;
                     end
                  end
               end
               default: begin
                  go_header = 1'b1;
               end
            endcase
         end else begin
            // drop source bytes outside a copy and cmd 3
            e0_v = 1'b0;
         end
      end

      if (go_header) begin
         phase_in     = PH_HEADER;
         count_in     = '0;
         magic_bad_in = 1'b0;
         assembly_in  = '0;
      end

      e0.last = !e1_v;
      e1.last = 1'b1;
   end

   assign push.v0 = e0_v;
   assign push.v1 = e1_v;
   assign push.r0 = e0;
   assign push.r1 = e1;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HEADER;
         count_ff       <= '0;
         magic_bad_ff   <= 1'b0;
         assembly_ff    <= '0;
         source_len_ff  <= '0;
         remaining_ff   <= '0;
         copy_offset_ff <= '0;
         copy_length_ff <= '0;
         expected_ff    <= '0;
         running_ff     <= '0;
         bytes_left_ff  <= '0;
      end else begin
         phase_ff       <= phase_in;
         count_ff       <= count_in;
         magic_bad_ff   <= magic_bad_in;
         assembly_ff    <= assembly_in;
         source_len_ff  <= source_len_in;
         remaining_ff   <= remaining_in;
         copy_offset_ff <= copy_offset_in;
         copy_length_ff <= copy_length_in;
         expected_ff    <= expected_in;
         running_ff     <= running_in;
         bytes_left_ff  <= bytes_left_in;
      end
   end

endmodule

// ===== hw/rtl/bpsa_rsp_fifo.sv =====
// Four-entry response queue taking up to two words per cycle and giving one.
// Depends on bpsa_pkg.
module bpsa_rsp_fifo (
   input  logic               clock,
   input  logic               reset,
   input  bpsa_pkg::push_type push,
   input  logic               pop,
   output bpsa_pkg::rsp_type  head,
   output logic               not_empty,
   output logic               room_two
);
   import bpsa_pkg::*;

   localparam int DEPTH = 4;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   rsp_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   n_push;
   logic               do_pop;

   assign not_empty = (count_ff != '0);
   assign room_two  = (count_ff <= CNT_W'(DEPTH - 2));
   assign head      = entry_ff[rd_ptr_ff];
   assign do_pop    = pop && not_empty;
   assign n_push    = CNT_W'(push.v0) + CNT_W'(push.v1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(n_push);
      rd_ptr_in = rd_ptr_ff + PTR_W'(do_pop);
      count_in  = count_ff + n_push - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.v0) begin
         entry_ff[wr_ptr_ff] <= push.r0;
      end
      if (push.v1) begin
         entry_ff[wr_ptr_ff + PTR_W'(1)] <= push.r1;
      end
   end

endmodule

// ===== hw/rtl/binary_patch_stream_applier.sv =====
// Top level of the binary patch stream applier: request handshake, parser
// core and response queue. Depends on bpsa_pkg, bpsa_if, bpsa_core, bpsa_rsp_fifo.
//
// Usage:
//   req_if carries one word per handshake: cmd 0 patch byte, cmd 1 end of
//   patch, cmd 2 source byte asked for by an earlier fetch result. rsp_if
//   returns result words: output bytes, fetch requests, done and errors; last
//   marks the final word caused by one request word.
//   Results of an accepted word are written into the response queue in the
//   cycle after it is taken. Throughput: one request word per cycle while the
//   response side drains; a word that yields two results (the closing byte
//   of a section followed by an error) takes two places in the response queue.
//   The four-word response queue sets ready: a word is taken while at most
//   two words are queued, so with a stalled receiver ready drops once three
//   or four words are queued, and nothing is lost.
//   Reset (synchronous, active high) empties the queue and puts the parser
//   in the wait-for-header state with all counters cleared.
//   Words that do not fit the current phase (source bytes outside a copy,
//   patch bytes or end of patch during a copy, cmd 3) are accepted and
//   dropped without a result.
module binary_patch_stream_applier (
   input  logic            clock,
   input  logic            reset,
   bpsa_req_if.sink        req_if,
   bpsa_rsp_if.source      rsp_if
);
   import bpsa_pkg::*;

   push_type  push;
   rsp_type   head;
   logic      accept;
   logic      not_empty;
   logic      room_two;

   assign req_if.ready = room_two;
   assign accept       = req_if.valid && room_two;

   bpsa_core u_core (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .cmd    (req_if.cmd),
      .data   (req_if.data),
      .push   (push)
   );

   bpsa_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (rsp_if.ready),
      .head      (head),
      .not_empty (not_empty),
      .room_two  (room_two)
   );

   assign rsp_if.valid        = not_empty;
   assign rsp_if.kind         = head.kind;
   assign rsp_if.out_byte     = head.out_byte;
   assign rsp_if.fetch_offset = head.fetch_offset;
   assign rsp_if.fetch_length = head.fetch_length;
   assign rsp_if.error_code   = head.error_code;
   assign rsp_if.last         = head.last;

endmodule

// ===== hw/rtl/bpsa_checker.sv =====
// Port-level checks for the binary patch stream applier, bound to the top.
// Depends on bpsa_pkg and binary_patch_stream_applier.
module bpsa_port_props (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [bpsa_pkg::KIND_W-1:0]   rsp_kind,
   input logic [bpsa_pkg::BYTE_W-1:0]   rsp_out_byte,
   input logic [bpsa_pkg::WORD_W-1:0]   rsp_fetch_offset,
   input logic [bpsa_pkg::WORD_W-1:0]   rsp_fetch_length,
   input logic [bpsa_pkg::CODE_W-1:0]   rsp_error_code,
   input logic                          rsp_last
);
   import bpsa_pkg::*;

   // hold a stalled word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_out_byte)
         && $stable(rsp_fetch_offset) && $stable(rsp_fetch_length)
         && $stable(rsp_error_code) && $stable(rsp_last))
      else $error("stalled response word changed");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request side stalled with empty response queue");

   a_final_kinds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_BYTE |-> rsp_last)
      else $error("fetch, done or error word not marked last");

   a_fetch_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_FETCH |-> rsp_fetch_offset == '0 && rsp_fetch_length == '0)
      else $error("fetch fields set on a non-fetch word");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind binary_patch_stream_applier bpsa_port_props u_bpsa_port_props (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_if.ready),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_kind         (rsp_if.kind),
   .rsp_out_byte     (rsp_if.out_byte),
   .rsp_fetch_offset (rsp_if.fetch_offset),
   .rsp_fetch_length (rsp_if.fetch_length),
   .rsp_error_code   (rsp_if.error_code),
   .rsp_last         (rsp_if.last)
);

// ===== sim/bpsa_checker.sv =====
// Checker for the binary patch stream applier: watches the request and response
// channels, predicts the response words and compares them field by field.
// Depends on bpsa_pkg and bpsa_if.
module bpsa_checker (
   input  logic clock,
   input  logic reset,
   bpsa_req_if  req_mon,
   bpsa_rsp_if  rsp_mon,
   output int   fail_count,
   output int   pending_count,
   output int   checked_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import bpsa_pkg::*;

   phase_type                phase;
   logic [IDX_W-1:0]         hdr_count;
   logic                     magic_bad;
   logic [WORD_W-1:0]        field_acc;
   logic [WORD_W-1:0]        src_len;
   logic signed [DEST_W-1:0] dest_left;
   logic [WORD_W-1:0]        copy_ofs;
   logic [WORD_W-1:0]        sect_len;
   logic [WORD_W-1:0]        want_sum;
   logic [WORD_W-1:0]        run_sum;
   logic [WORD_W-1:0]        bytes_left;

   rsp_type expected_rsp_q[$];
   int      word_results;
   int      errors  = 0;
   int      checked = 0;

   task automatic push_rsp(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] b,
                           input logic [WORD_W-1:0] ofs, input logic [WORD_W-1:0] len,
                           input logic [CODE_W-1:0] code);
      rsp_type r;
      rsp_type prev;
      // only the final word caused by one request keeps last set
      if (word_results > 0) begin
         prev      = expected_rsp_q.pop_back();
         prev.last = 1'b0;
         expected_rsp_q.push_back(prev);
      end
      r              = '0;
      r.kind         = kind;
      r.out_byte     = b;
      r.fetch_offset = ofs;
      r.fetch_length = len;
      r.error_code   = code;
      r.last         = 1'b1;
      expected_rsp_q.push_back(r);
      word_results++;
   endtask

   task automatic rearm_header();
      phase     = PH_HEADER;
      hdr_count = '0;
      magic_bad = 1'b0;
      field_acc = '0;
   endtask

   task automatic raise_error(input logic [CODE_W-1:0] code, input logic [BYTE_W-1:0] b);
      push_rsp(KIND_ERROR, b, '0, '0, code);
      rearm_header();
   endtask

   task automatic close_section(input logic [WORD_W-1:0] size);
      dest_left = dest_left - $signed({2'b00, size});
      if (dest_left[DEST_W-1]) raise_error(ERR_TOO_LONG, '0);
      else phase = PH_TAG;
   endtask

   task automatic predict_word(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] b);
      logic [IDX_W-1:0] idx;
      idx          = hdr_count;
      word_results = 0;
      if (phase == PH_SOURCE) begin
         if (cmd == CMD_SOURCE) begin
            run_sum = {run_sum[WORD_W-3:0], run_sum[WORD_W-1:WORD_W-2]} ^ {{24{b[7]}}, b};
            push_rsp(KIND_BYTE, b, '0, '0, '0);
            bytes_left = bytes_left - 1'b1;
            if (bytes_left == '0) begin
               if (run_sum != want_sum) raise_error(ERR_CHECKSUM, '0);
               else close_section(sect_len);
            end
         end
      end else if (cmd == CMD_END) begin
         case (phase)
            PH_HEADER: raise_error(ERR_BAD_HEADER, '0);
            PH_TAG: begin
               if (dest_left != '0) raise_error(ERR_TOO_SHORT, '0);
               else begin
                  push_rsp(KIND_DONE, '0, '0, '0, '0);
                  rearm_header();
               end
            end
            default: raise_error(ERR_EARLY_END, '0);
         endcase
      end else if (cmd == CMD_PATCH) begin
         case (phase)
            PH_HEADER: begin
               if (idx <= IDX_MAGIC_LAST) begin
                  if (b != MAGIC[idx[2:0]]) magic_bad = 1'b1;
               end else begin
                  field_acc = {b, field_acc[WORD_W-1:8]};
               end
               if (idx == IDX_SRC_LAST) src_len = field_acc;
               if (idx == IDX_HDR_LAST) begin
                  dest_left = $signed({2'b00, field_acc});
                  if (magic_bad) raise_error(ERR_BAD_HEADER, '0);
                  else begin
                     phase     = PH_TAG;
                     hdr_count = '0;
                  end
               end else begin
                  hdr_count = idx + 1'b1;
               end
            end
            PH_TAG: begin
               hdr_count = '0;
               if (b == TAG_COPY) phase = PH_COPYHDR;
               else if (b == TAG_LITERAL) phase = PH_LITHDR;
               else raise_error(ERR_BAD_TAG, b);
            end
            PH_COPYHDR: begin
               field_acc = {b, field_acc[WORD_W-1:8]};
               hdr_count = idx + 1'b1;
               if (idx == IDX_FIELD0_LAST) copy_ofs = field_acc;
               else if (idx == IDX_FIELD1_LAST) sect_len = field_acc;
               else if (idx == IDX_FIELD2_LAST) begin
                  want_sum  = field_acc;
                  hdr_count = '0;
                  // the end of the range must not wrap past 32 bits
                  if (sect_len == '0 || copy_ofs > src_len || sect_len > src_len ||
                      ({1'b0, copy_ofs} + {1'b0, sect_len}) > {1'b0, src_len}) begin
                     raise_error(ERR_BAD_RANGE, '0);
                  end else begin
                     push_rsp(KIND_FETCH, '0, copy_ofs, sect_len, '0);
                     run_sum    = '0;
                     bytes_left = sect_len;
                     phase      = PH_SOURCE;
                  end
               end
            end
            PH_LITHDR: begin
               field_acc = {b, field_acc[WORD_W-1:8]};
               hdr_count = idx + 1'b1;
               if (idx == IDX_FIELD0_LAST) begin
                  hdr_count  = '0;
                  sect_len   = field_acc;
                  bytes_left = field_acc;
                  if (bytes_left == '0) close_section('0);
                  else phase = PH_LITERAL;
               end
            end
            PH_LITERAL: begin
               push_rsp(KIND_BYTE, b, '0, '0, '0);
               bytes_left = bytes_left - 1'b1;
               if (bytes_left == '0) close_section(sect_len);
            end
            default: rearm_header();
         endcase
      end
   endtask

   task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                              input logic [WORD_W-1:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         errors++;
      end
   endtask

   task automatic check_rsp();
      rsp_type want;
      if (expected_rsp_q.size() == 0) begin
         $error("response word of kind %0d with nothing expected", rsp_mon.kind);
         errors++;
      end else begin
         want = expected_rsp_q.pop_front();
         check_field("kind", WORD_W'(want.kind), WORD_W'(rsp_mon.kind));
         check_field("out_byte", WORD_W'(want.out_byte), WORD_W'(rsp_mon.out_byte));
         check_field("fetch_offset", want.fetch_offset, rsp_mon.fetch_offset);
         check_field("fetch_length", want.fetch_length, rsp_mon.fetch_length);
         check_field("error_code", WORD_W'(want.error_code), WORD_W'(rsp_mon.error_code));
         check_field("last", WORD_W'(want.last), WORD_W'(rsp_mon.last));
      end
      checked++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rearm_header();
         src_len    = '0;
         dest_left  = '0;
         copy_ofs   = '0;
         sect_len   = '0;
         want_sum   = '0;
         run_sum    = '0;
         bytes_left = '0;
         expected_rsp_q.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) predict_word(req_mon.cmd, req_mon.data);
         if (rsp_mon.valid && rsp_mon.ready) check_rsp();
      end
      fail_count    <= errors;
      pending_count <= expected_rsp_q.size();
      checked_count <= checked;
   end

endmodule

// ===== sim/tb_binary_patch_stream_applier.sv =====
// Testbench top for the binary patch stream applier: builds directed and random
// patches, paces both channels and reports the verdict.
// Depends on bpsa_pkg, bpsa_if, bpsa_checker and the block itself.
module tb_binary_patch_stream_applier;
   timeunit 1ns;
   timeprecision 1ps;
   import bpsa_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;
   localparam int               ITEM_TARGET = 1850;
   localparam int               CYCLE_LIMIT = 1000000;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [BYTE_W-1:0] data;
   } req_word_type;

   logic clock;
   logic reset;
   int   cycle_count = 0;
   int   fails;
   int   pending;
   int   checked;
   int   sent_words  = 0;
   int   patch_count = 0;
   bit   calm_src    = 1'b0;
   bit   calm_sink   = 1'b0;

   req_word_type patch_words[$];

   bpsa_req_if req_bus ();
   bpsa_rsp_if rsp_bus ();

   binary_patch_stream_applier u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   bpsa_checker u_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .fail_count    (fails),
      .pending_count (pending),
      .checked_count (checked)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic void put(input logic [CMD_W-1:0] c, input logic [BYTE_W-1:0] d);
      req_word_type w;
      w.cmd  = c;
      w.data = d;
      patch_words.push_back(w);
   endfunction

   function automatic void put32(input logic [WORD_W-1:0] v);
      for (int i = 0; i < 4; i++) put(CMD_PATCH, v[8*i +: 8]);
   endfunction

   function automatic void put_header(input logic [WORD_W-1:0] src,
                                      input logic [WORD_W-1:0] dst, input bit bad_magic);
      int                pick;
      logic [BYTE_W-1:0] b;
      pick = $urandom_range(0, 7);
      for (int i = 0; i < 8; i++) begin
         b = MAGIC[i];
         if (bad_magic && i == pick) b = b ^ (8'h01 << $urandom_range(0, 7));
         put(CMD_PATCH, b);
      end
      put32(src);
      put32(dst);
   endfunction

   function automatic void put_literal(input logic [WORD_W-1:0] len);
      put(CMD_PATCH, TAG_LITERAL);
      put32(len);
      for (int i = 0; i < len; i++) put(CMD_PATCH, BYTE_W'($urandom_range(0, 255)));
   endfunction

   // flip corrupts the checksum field; nsrc is how many source words follow
   function automatic void put_copy(input logic [WORD_W-1:0] ofs, input logic [WORD_W-1:0] len,
                                    input int nsrc, input logic [WORD_W-1:0] flip);
      logic [BYTE_W-1:0] src_bytes[$];
      logic [WORD_W-1:0] sum;
      logic [BYTE_W-1:0] b;
      sum = '0;
      for (int i = 0; i < nsrc; i++) begin
         b = BYTE_W'($urandom_range(0, 255));
         src_bytes.push_back(b);
         sum = {sum[WORD_W-3:0], sum[WORD_W-1:WORD_W-2]} ^ {{24{b[7]}}, b};
      end
      put(CMD_PATCH, TAG_COPY);
      put32(ofs);
      put32(len);
      put32(sum ^ flip);
      foreach (src_bytes[i]) begin
         // stray words during a copy are dropped by the block
         if ($urandom_range(0, 19) == 0) begin
            case ($urandom_range(0, 2))
               0:       put(CMD_PATCH, BYTE_W'($urandom_range(0, 255)));
               1:       put(CMD_END, BYTE_W'($urandom_range(0, 255)));
               default: put(CMD_UNUSED, BYTE_W'($urandom_range(0, 255)));
            endcase
         end
         put(CMD_SOURCE, src_bytes[i]);
      end
   endfunction

   function automatic void random_patch();
      logic [WORD_W-1:0] src;
      logic [WORD_W-1:0] dst;
      logic [WORD_W-1:0] ofs;
      logic [WORD_W-1:0] len;
      logic [WORD_W-1:0] flip;
      longint            total;
      int                nsec;
      int                r;
      int                k;
      bit                building;
      bit                cut;
      req_word_type      w;
      if ($urandom_range(0, 99) < 3) begin
         // end of patch inside the file header
         put_header($urandom, $urandom, 1'b0);
         k = $urandom_range(0, 15);
         while (patch_words.size() > k) void'(patch_words.pop_back());
         put(CMD_END, BYTE_W'($urandom_range(0, 255)));
         return;
      end
      case ($urandom_range(0, 9))
         0:       src = '0;
         1:       src = '1;
         2, 3:    src = $urandom;
         default: src = $urandom_range(1, 64);
      endcase
      put_header(src, '0, $urandom_range(0, 19) == 0);
      total    = 0;
      building = 1'b1;
      cut      = 1'b0;
      nsec     = $urandom_range(0, 5);
      for (int s = 0; s < nsec && building; s++) begin
         if ($urandom_range(0, 24) == 0)
            put($urandom_range(0, 1) ? CMD_SOURCE : CMD_UNUSED, BYTE_W'($urandom_range(0, 255)));
         r = $urandom_range(0, 99);
         if (r < 45) begin
            k = $urandom_range(0, 19);
            if (src == '0 || k < 3) begin
               case (k)
                  0:       begin len = '0; ofs = $urandom_range(0, 3); end
                  1:       begin ofs = '1; len = $urandom_range(1, 4); end
                  2:       begin ofs = $urandom_range(0, 3); len = src + 1'b1; end
                  default: begin ofs = $urandom; len = $urandom_range(1, 6); end
               endcase
               put_copy(ofs, len, 0, '0);
               repeat ($urandom_range(0, 2)) put(CMD_SOURCE, BYTE_W'($urandom_range(0, 255)));
               building = 1'b0;
            end else begin
               len = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
               if (len > src) len = src;
               if ($urandom_range(0, 4) == 0) ofs = src - len;
               else ofs = $urandom % (src - len + 1'b1);
               flip = ($urandom_range(0, 9) == 0) ? (32'h1 << $urandom_range(0, 31)) : '0;
               put_copy(ofs, len, len, flip);
               total += len;
               if (flip != '0) building = 1'b0;
            end
         end else if (r < 88) begin
            len = ($urandom_range(0, 6) == 0) ? $urandom_range(9, 30) : $urandom_range(0, 8);
            put_literal(len);
            total += len;
         end else if (r < 92) begin
            do k = $urandom_range(0, 255); while (k == TAG_COPY || k == TAG_LITERAL);
            put(CMD_PATCH, BYTE_W'(k));
            building = 1'b0;
         end else begin
            // section cut short by end of patch
            case ($urandom_range(0, 2))
               0: begin
                  put(CMD_PATCH, TAG_COPY);
                  repeat ($urandom_range(0, 11)) put(CMD_PATCH, BYTE_W'($urandom_range(0, 255)));
               end
               1: begin
                  put(CMD_PATCH, TAG_LITERAL);
                  repeat ($urandom_range(0, 3)) put(CMD_PATCH, BYTE_W'($urandom_range(0, 255)));
               end
               default: begin
                  put(CMD_PATCH, TAG_LITERAL);
                  put32(32'h8000_0000 | $urandom);
                  repeat ($urandom_range(0, 5)) put(CMD_PATCH, BYTE_W'($urandom_range(0, 255)));
               end
            endcase
            building = 1'b0;
            cut      = 1'b1;
         end
      end
      r = $urandom_range(0, 19);
      if (r < 14) dst = WORD_W'(total);
      else if (r < 16) dst = WORD_W'(total) + $urandom_range(1, 5);
      else if (r < 18 && total > 0) dst = WORD_W'(total) - $urandom_range(1, 1 + (total > 3 ? 3 : total - 1));
      else if (r == 18) dst = '1;
      else dst = $urandom;
      // fill in the destination length now that the sections are known
      for (int i = 0; i < 4; i++) begin
         w                  = patch_words[12 + i];
         w.data             = dst[8*i +: 8];
         patch_words[12 + i] = w;
      end
      if (cut || (building && $urandom_range(0, 9) != 0) || $urandom_range(0, 3) == 0)
         put(CMD_END, BYTE_W'($urandom_range(0, 255)));
   endfunction

   task automatic send_word(input req_word_type w);
      int gap;
      gap = calm_src ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.cmd   <= w.cmd;
      req_bus.data  <= w.data;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic ship();
      foreach (patch_words[i]) begin
         send_word(patch_words[i]);
         sent_words++;
      end
      patch_words.delete();
      patch_count++;
   endtask

   // response side: hold ready low for a drawn stall before each word
   initial begin
      int stall;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 63) == 0) calm_sink = !calm_sink;
         stall = calm_sink ? 0 : $urandom_range(0, 16);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   initial begin
      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.cmd   <= CMD_PATCH;
      req_bus.data  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty patch, with stray words first
      put(CMD_SOURCE, 8'h00);
      put(CMD_UNUSED, 8'hA5);
      put(CMD_END, 8'hFF);
      ship();
      // minimal good patch
      put_header('0, '0, 1'b0);
      put(CMD_END, 8'h00);
      ship();
      // bad magic, then end with no header bytes
      put_header('0, '0, 1'b1);
      put(CMD_END, 8'h5A);
      ship();
      // copy range that wraps past 32 bits
      put_header('1, '1, 1'b0);
      put_copy('1, 32'd1, 0, '0);
      ship();
      // zero-size copy
      put_header(32'd8, '0, 1'b0);
      put_copy('0, '0, 0, '0);
      ship();
      // copy ending on the source boundary, empty literal, one literal byte
      put_header(32'd16, 32'd9, 1'b0);
      put_copy(32'd8, 32'd8, 8, '0);
      put_literal('0);
      put_literal(32'd1);
      put(CMD_END, 8'h00);
      ship();
      // checksum mismatch
      put_header(32'd4, 32'd4, 1'b0);
      put_copy('0, 32'd4, 4, 32'h8000_0000);
      ship();
      // destination overrun, then underrun
      put_header('0, 32'd1, 1'b0);
      put_literal(32'd2);
      ship();
      put_header('0, 32'd5, 1'b0);
      put_literal(32'd1);
      put(CMD_END, 8'h00);
      ship();
      // bad tag, then end inside a section header
      put_header('0, '0, 1'b0);
      put(CMD_PATCH, 8'h00);
      ship();
      put_header('0, '0, 1'b0);
      put(CMD_PATCH, TAG_LITERAL);
      put(CMD_PATCH, 8'h01);
      put(CMD_END, 8'h00);
      ship();

      while (sent_words < ITEM_TARGET) begin
         if ($urandom_range(0, 5) == 0) calm_src = !calm_src;
         random_patch();
         ship();
      end
      req_bus.valid <= 1'b0;

      // drain: let the last expectations land, then wait them out
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("covered %0d request words in %0d patches; %0d response words compared",
               sent_words, patch_count, checked);
      if (fails == 0 && pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== binary_patch_stream_applier.f =====
hw/rtl/bpsa_pkg.sv
hw/rtl/bpsa_if.sv
hw/rtl/bpsa_core.sv
hw/rtl/bpsa_rsp_fifo.sv
hw/rtl/binary_patch_stream_applier.sv
hw/rtl/bpsa_checker.sv
sim/bpsa_checker.sv
sim/tb_binary_patch_stream_applier.sv
